>>> src/fvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvm_pkg
// Shared types and constants for the valid-mode FIR filter.
// ----------------------------------------------------------------------------
package fvm_pkg;

	localparam int MAX_TAPS = 7;
	localparam int SMP_W = 16;
	localparam int FRAC_W = 15;
	localparam int TAP_W = $clog2(MAX_TAPS + 1);
	localparam int CFG_IDX_W = $clog2(MAX_TAPS + 1);
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int FILL_W = 3;
	localparam int HALF_TAPS = (MAX_TAPS + 1) / 2;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = CFG_IDX_W'(1);
	localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};
	localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(5);

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    first_of_block;
		logic                    last_of_block;
	} in_beat_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] filtered;
		logic                    last_result;
	} out_beat_t;

endpackage
`default_nettype wire

>>> src/fvm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvm_cell
// One tap cell: holds one delay-line sample and registers its product.
// ----------------------------------------------------------------------------
module fvm_cell (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  fvm_pkg::smp_t    sin,
	input  fvm_pkg::smp_t    coef,
	output fvm_pkg::smp_t    sout,
	output fvm_pkg::prod_t   prod
);
	import fvm_pkg::*;

	smp_t  dly_q;
	prod_t prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '0;
		end else if (en) begin
			dly_q <= sin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= coef * sin;
		end
	end

	assign sout = dly_q;
	assign prod = prod_s1;

endmodule
`default_nettype wire

>>> src/fir_filter_valid_mode_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_valid_mode_core
// Streaming valid-mode FIR filter, Q1.15, built from a row of tap cells.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the smp channel (valid/ready), results leave on the res
//   channel (valid/ready). A beat is taken when valid and ready are both high.
//   A sample produces a result once tap_count samples of its block are in;
//   earlier samples of a block produce nothing. first_of_block restarts the
//   count, last_of_block is copied to last_result.
//   Configuration: cfg_en writes cfg_data to register cfg_index (0 tap_count,
//   1..7 coef_0..coef_6); write only while the block is idle.
//   Registers from sample beat to result valid: products, partial sums,
//   final sum with rounding and saturation in the output register.
//   Throughput: one sample per cycle while smp_ready is high; all taps
//   multiply in parallel, one multiplier per cell.
//   Reset clears the delay line and fill count, sets tap_count to 5 and all
//   coefficients to 0. No clearing pass; ready rises right after reset.
//   When res_ready is low the result holds; samples are still taken while
//   the pipeline has empty stages, and smp_ready drops only when it is full.
// ----------------------------------------------------------------------------
module fir_filter_valid_mode_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_en,
	input  wire [fvm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [fvm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                smp_valid,
	output logic                               smp_ready,
	input  fvm_pkg::in_beat_t                  smp,
	output logic                               res_valid,
	input  wire                                res_ready,
	output fvm_pkg::out_beat_t                 res
);
	import fvm_pkg::*;

	logic [TAP_W-1:0]  tap_count_q;
	smp_t              coef_q [MAX_TAPS];
	logic [FILL_W-1:0] fill_q;

	logic [TAP_W-1:0]  taps;
	logic [FILL_W-1:0] fill_nxt;
	logic              accept;
	logic              emit;

	smp_t  chain [MAX_TAPS+1];
	smp_t  coef_sel [MAX_TAPS];
	prod_t prod [MAX_TAPS];

	logic  v_s1, last_s1;
	logic  v_s2, last_s2;
	acc_t  sum_a_s2, sum_b_s2;
	logic  ready1, ready2, ready3;
	acc_t  sum_a, sum_b;
	acc_t  total, rnd;
	logic [ACC_W-FRAC_W-1:0] hi;
	smp_t  sat;
	out_beat_t res_q;
	logic  res_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_RESET;
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_en) begin
			if (cfg_index == REG_TAP_COUNT) begin
				tap_count_q <= cfg_data[TAP_W-1:0];
			end else if (cfg_index <= CFG_IDX_W'(MAX_TAPS)) begin
				coef_q[cfg_index - REG_COEF_0] <= cfg_data[SMP_W-1:0];
			end
		end
	end

	always_comb begin
		if (tap_count_q == '0) begin
			taps = TAP_W'(1);
		end else if (tap_count_q > TAP_W'(MAX_TAPS)) begin
			taps = TAP_W'(MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
	end

	// handshake and stage readiness
	assign ready3 = !res_valid_q || res_ready;
	assign ready2 = !v_s2 || ready3;
	assign ready1 = !v_s1 || ready2;
	assign smp_ready = ready1;
	assign accept = smp_valid && ready1;

	// window fill
	always_comb begin
		fill_nxt = smp.first_of_block ? '0 : fill_q;
		if (fill_nxt != FILL_MAX) begin
			fill_nxt = fill_nxt + FILL_W'(1);
		end
	end
	assign emit = FILL_W'(taps) <= fill_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nxt;
		end
	end

	// tap cells: cell k sees the sample of age k
	assign chain[0] = smp.sample;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		always_comb begin
			if (TAP_W'(k) < taps) begin
				coef_sel[k] = coef_q[TAP_W'(taps - TAP_W'(1) - TAP_W'(k))];
			end else begin
				coef_sel[k] = '0;
			end
		end

		fvm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.sin    (chain[k]),
			.coef   (coef_sel[k]),
			.sout   (chain[k+1]),
			.prod   (prod[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready1) begin
			v_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= smp.last_of_block;
		end
	end

	// partial sums
	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (i < HALF_TAPS) begin
				sum_a = sum_a + ACC_W'(prod[i]);
			end else begin
				sum_b = sum_b + ACC_W'(prod[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && v_s1) begin
			sum_a_s2 <= sum_a;
			sum_b_s2 <= sum_b;
			last_s2  <= last_s1;
		end
	end

	// final sum, round half up, saturate
	assign total = sum_a_s2 + sum_b_s2;
	assign rnd = total + (ACC_W'(1) <<< (FRAC_W - 1));
	assign hi = rnd[ACC_W-1:FRAC_W];

	always_comb begin
		if (hi[ACC_W-FRAC_W-1:SMP_W-1] == '0 || hi[ACC_W-FRAC_W-1:SMP_W-1] == '1) begin
			sat = hi[SMP_W-1:0];
		end else if (hi[ACC_W-FRAC_W-1]) begin
			sat = {1'b1, {(SMP_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SMP_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ready3) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready3 && v_s2) begin
			res_q.filtered    <= sat;
			res_q.last_result <= last_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// checks
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_ready |-> (res_valid && v_s1 && v_s2))
		else $error("input stalled with an empty stage");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fill_q != '0))
		else $error("fill count zero after a sample beat");

	a_first_short: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && smp.first_of_block && taps != TAP_W'(1)) |=> !v_s1)
		else $error("result from a block start with more than one tap");

	a_single_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && taps == TAP_W'(1)) |=> v_s1)
		else $error("one-tap filter dropped a result");

endmodule
`default_nettype wire
